// ----- rtl/mvm_pkg.sv -----
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, sizes and codes for the matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // Sizes
  localparam int MAX_DIM     = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int OUT_LIMIT   = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int DIM_W       = $clog2(OUT_LIMIT);          // row/column counter
  localparam int VADDR_W     = $clog2(MAX_DIM);            // vector store address
  localparam int MADDR_W     = $clog2(MAX_DIM * MAX_DIM);  // matrix store address
  localparam int ACC_W       = 2 * VALUE_WIDTH + DIM_W;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;

  // Action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_VECTOR = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSED = 2'd2;

  typedef struct packed {
    logic               action;
    logic [3:0]         entry_row;
    logic [3:0]         entry_col;
    logic [3:0]         vector_index;
    logic signed [15:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               last_result;
  } out_t;

  // Control word that travels with each MAC operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Dimension 0 acts as 1, above the limit acts as the limit
  function automatic logic [DIM_W:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W:0] r;
    if (d == '0) begin
      r = (DIM_W+1)'(1);
    end else if (32'(d) > OUT_LIMIT) begin
      r = (DIM_W+1)'(OUT_LIMIT);
    end else begin
      r = (DIM_W+1)'(d);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mvm_ram.sv -----
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mvm_mac.sv -----
// ----------------------------------------------------------------------------
// mvm_mac
// Multiply-accumulate unit: registered product, accumulator, then round to
// 12 fraction bits and saturate to 32 bits.
// ----------------------------------------------------------------------------
module mvm_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mvm_pkg::mac_ctl_t                      ctl,
  input  logic signed [mvm_pkg::VALUE_WIDTH-1:0] mat_val,
  input  logic signed [mvm_pkg::VALUE_WIDTH-1:0] vec_val,
  output logic                                   res_valid,
  output logic signed [31:0]                     res_value,
  output logic                                   busy
);
  import mvm_pkg::*;

  localparam int QW = ACC_W + 1 - FRAC_BITS;
  localparam int EW = (QW > 32) ? QW + 1 : 33;
  localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  mac_ctl_t                         p_ctl;
  logic signed [2*VALUE_WIDTH-1:0]  prod;
  logic signed [ACC_W-1:0]          acc;
  logic                             acc_done;
  logic signed [ACC_W:0]            rnd;
  logic signed [QW-1:0]             q;
  logic signed [EW-1:0]             qx;
  logic signed [31:0]               sat;

  // Round half up: add half an LSB, then arithmetic shift
  assign rnd = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
  assign q   = QW'(rnd >>> FRAC_BITS);
  assign qx  = EW'(q);

  always_comb begin
    if (qx > SAT_HI) begin
      sat = 32'sh7FFF_FFFF;
    end else if (qx < SAT_LO) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl     <= '0;
      acc_done  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p_ctl     <= ctl;
      acc_done  <= p_ctl.valid & p_ctl.last;
      res_valid <= acc_done;
    end
    prod <= mat_val * vec_val;
    if (p_ctl.valid) begin
      acc <= p_ctl.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (acc_done) begin
      res_value <= sat;
    end
  end

  assign busy = ctl.valid | p_ctl.valid | acc_done | res_valid;

endmodule

// ----- rtl/matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Matrix-vector product on Q4.12 operands with saturated Q20.12 results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): action 0 writes one matrix
//   entry, action 1 stores one vector element. An element flagged last
//   starts the product; the input channel stalls until the product is done.
//   Output channel (out_valid/out_stall/out_data): one request per product
//   element, in index order, last_result set on the final one.
//   Config port (cfg_we/cfg_index/cfg_data): num_rows, num_cols, transposed.
// Timing:
//   Write and plain vector requests are accepted while the sequencer is
//   idle. For each result, the n_in matrix/vector store reads (n_in =
//   vector length in use) pass through the single shared MAC, then the
//   multiply, accumulate, round and output stages. The next result starts
//   once the output register is free, so a stalled receiver holds the
//   sequencer.
// Reset: registers return to 16 x 16, not transposed; the vector store reads
//   as all zero; matrix entries are undefined until written.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mvm_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mvm_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvm_pkg::CFG_W-1:0]       cfg_data
);
  import mvm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_ISSUE} state_t;

  state_t                   state;
  logic [CFG_W-1:0]         num_rows;
  logic [CFG_W-1:0]         num_cols;
  logic                     transposed;

  logic [DIM_W-1:0]         row_i;
  logic [DIM_W-1:0]         col_k;
  logic [DIM_W:0]           n_out;
  logic [DIM_W:0]           n_in;
  logic                     rows_done;
  logic [DIM_W-1:0]         out_idx;
  logic [MAX_DIM-1:0]       vec_valid;

  logic                     in_accept;
  logic                     mat_we;
  logic                     vec_we;
  logic [MADDR_W-1:0]       mat_waddr;
  logic [MADDR_W-1:0]       mat_raddr;
  logic [VADDR_W-1:0]       vec_waddr;
  logic [VADDR_W-1:0]       vec_raddr;
  logic [DIM_W-1:0]         rd_row;
  logic [DIM_W-1:0]         rd_col;
  logic [VALUE_WIDTH-1:0]   in_operand;
  logic [VALUE_WIDTH-1:0]   mat_rdata;
  logic [VALUE_WIDTH-1:0]   vec_rdata;
  logic signed [VALUE_WIDTH-1:0] vec_op;

  mac_ctl_t                 iss_ctl;
  mac_ctl_t                 mac_ctl;
  logic                     vq_valid;
  logic                     k_last;
  logic                     mac_busy;
  logic                     res_valid;
  logic signed [31:0]       res_value;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid & ~in_stall;
  assign in_operand = VALUE_WIDTH'(in_data.value);

  // Store writes
  assign mat_we    = in_accept && (in_data.action == ACT_WRITE) &&
                     (32'(in_data.entry_row) < MAX_DIM) &&
                     (32'(in_data.entry_col) < MAX_DIM);
  assign mat_waddr = MADDR_W'(32'(in_data.entry_row) * MAX_DIM + 32'(in_data.entry_col));
  assign vec_we    = in_accept && (in_data.action == ACT_VECTOR) &&
                     (32'(in_data.vector_index) < MAX_DIM);
  assign vec_waddr = VADDR_W'(in_data.vector_index);

  // Store reads: row-major for normal mode, column-major for transposed
  assign rd_row    = transposed ? col_k : row_i;
  assign rd_col    = transposed ? row_i : col_k;
  assign mat_raddr = MADDR_W'(32'(rd_row) * MAX_DIM + 32'(rd_col));
  assign vec_raddr = VADDR_W'(col_k);

  assign k_last = ((DIM_W+1)'(col_k) == n_in - (DIM_W+1)'(1));

  mvm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (in_operand),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mvm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_DIM)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (in_operand),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // Unwritten vector elements count as zero
  assign vec_op  = vq_valid ? $signed(vec_rdata) : '0;
  assign mac_ctl = iss_ctl;

  mvm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .mat_val   ($signed(mat_rdata)),
    .vec_val   (vec_op),
    .res_valid (res_valid),
    .res_value (res_value),
    .busy      (mac_busy)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows   <= CFG_W'(16);
      num_cols   <= CFG_W'(16);
      transposed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_ROWS:   num_rows   <= cfg_data;
        REG_NUM_COLS:   num_cols   <= cfg_data;
        REG_TRANSPOSED: transposed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iss_ctl   <= '0;
      vec_valid <= '0;
      out_valid <= 1'b0;
      rows_done <= 1'b0;
      row_i     <= '0;
      col_k     <= '0;
      out_idx   <= '0;
      n_out     <= (DIM_W+1)'(1);
      n_in      <= (DIM_W+1)'(1);
    end else begin
      iss_ctl.valid <= (state == S_ISSUE);
      iss_ctl.first <= (col_k == '0);
      iss_ctl.last  <= k_last;

      if (vec_we) begin
        vec_valid[vec_waddr] <= 1'b1;
      end

      if (res_valid) begin
        out_valid <= 1'b1;
        out_idx   <= out_idx + DIM_W'(1);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept && in_data.action == ACT_VECTOR && in_data.last) begin
            n_out     <= transposed ? clamp_dim(num_cols) : clamp_dim(num_rows);
            n_in      <= transposed ? clamp_dim(num_rows) : clamp_dim(num_cols);
            row_i     <= '0;
            col_k     <= '0;
            out_idx   <= '0;
            rows_done <= 1'b0;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          // One result in flight at a time; it lands in the output register
          if (!iss_ctl.valid && !mac_busy) begin
            if (rows_done) begin
              vec_valid <= '0;
              state     <= S_IDLE;
            end else if (!out_valid) begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            col_k <= '0;
            if ((DIM_W+1)'(row_i) == n_out - (DIM_W+1)'(1)) begin
              rows_done <= 1'b1;
            end else begin
              row_i <= row_i + DIM_W'(1);
            end
            state <= S_WAIT;
          end else begin
            col_k <= col_k + DIM_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    vq_valid <= vec_valid[vec_raddr];
    if (res_valid) begin
      out_data.result_index <= 4'(out_idx);
      out_data.result_value <= res_value;
      out_data.last_result  <= ((DIM_W+1)'(out_idx) == n_out - (DIM_W+1)'(1));
    end
  end

endmodule
